// File: design/csc_triangle_counter_core_macros.svh
// Assertion helpers for the triangle counter
`ifndef CSC_TRIANGLE_COUNTER_CORE_MACROS_SVH
`define CSC_TRIANGLE_COUNTER_CORE_MACROS_SVH
// Check a property on every edge outside reset
`define CSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle
`define CSC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// File: design/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxEdges = 8192;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int PW = EW + 1;
  localparam int CW = VW + 1;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_LOAD_COL = 2'd0;
  localparam logic [1:0] KIND_LOAD_ROW = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_EDGE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [13:0] index;
    logic [13:0] value;
  } in_t;

  typedef struct packed {
    logic [9:0] vertex;
    logic [31:0] vertex_triangles;
    logic [31:0] total_triangles;
  } out_t;

  // Bump request toward the counter memory
  typedef struct packed {
    logic valid;
    logic [VW-1:0] addr;
  } bump_t;
endpackage

// File: design/csc_triangle_counter_core.sv
`timescale 1ns / 1ps
// Loads: one per cycle while idle. Read: accepted only while idle; the result is registered in
//   S_READ_OUT after S_READ_WAIT, and no new request is taken before that. Start: clears 1024
//   counters, then binary-searches each column entry pair; a hit makes three counter updates.
// One read or start runs at a time; loads and the next request are accepted while a result
//   waits, and a new result is registered once the output register has emptied.
// Reset (sync, rst high): vertex_count 1, edge_count 0, total zero, then a clear of 1024 counters.
`include "csc_triangle_counter_core_macros.svh"
module csc_triangle_counter_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  csc_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output csc_pkg::out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [13:0] cfg_data
);
  localparam int VW = csc_pkg::VW;
  localparam int EW = csc_pkg::EW;
  localparam int PW = csc_pkg::PW;
  localparam int CW = csc_pkg::CW;

  typedef enum logic [4:0] {
    S_IDLE, S_READ_WAIT, S_READ_OUT, S_CLEAR, S_COL_A, S_COL_B, S_COL_C,
    S_M_CHECK, S_M_ROW, S_U_A, S_U_B, S_U_C, S_K_CHECK, S_K_ROW,
    S_SRCH, S_SRCH_W, S_SRCH_C, S_BUMP_R, S_BUMP_W, S_NEXT_M, S_DONE
  } state_t;

  state_t state;
  logic [10:0] vertex_count;
  logic [13:0] edge_count;
  logic [31:0] total;
  logic [CW-1:0] clr;
  logic clr_walk;
  logic [CW-1:0] vi;
  logic [PW-1:0] e_ptr, m_ptr, k_ptr, lo, hi, mid;
  logic [PW-1:0] u_lo, u_hi;
  logic [VW-1:0] u, key;
  logic [1:0] bsel;
  logic [VW-1:0] rd_vertex;
  logic rd_oor;

  // Column pointer memory
  logic col_we;
  logic [VW:0] col_waddr, col_raddr;
  logic [13:0] col_wdata, col_rdata;
  // Row memory
  logic row_we;
  logic [EW-1:0] row_waddr, row_raddr;
  logic [VW-1:0] row_wdata, row_rdata;
  // Counter memory
  logic cnt_we;
  logic [VW-1:0] cnt_waddr, cnt_raddr;
  logic [31:0] cnt_wdata, cnt_rdata;

  csc_ram #(.Width(14), .Depth(2 * csc_pkg::MaxVertices)) u_col (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata));
  csc_ram #(.Width(VW), .Depth(csc_pkg::MaxEdges)) u_row (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata));
  csc_ram #(.Width(32), .Depth(csc_pkg::MaxVertices)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));

  logic [PW-1:0] lim;
  logic [CW-1:0] nv;
  logic [PW-1:0] colp;
  logic in_acc;
  csc_pkg::bump_t bump;

  assign lim = (edge_count > 14'(csc_pkg::MaxEdges)) ? PW'(csc_pkg::MaxEdges)
                                                      : PW'(edge_count);
  assign nv = (vertex_count > 11'(csc_pkg::MaxVertices)) ? CW'(csc_pkg::MaxVertices)
                                                         : CW'(vertex_count);
  assign colp = (PW'(col_rdata) > lim) ? lim : PW'(col_rdata);
  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Select the counter to bump for the current hit
  always_comb begin
    bump.valid = (state == S_BUMP_R);
    case (bsel)
      2'd0: bump.addr = vi[VW-1:0];
      2'd1: bump.addr = u;
      default: bump.addr = key;
    endcase
  end

  // Drive memory ports
  always_comb begin
    col_we = in_acc && in_data.kind == csc_pkg::KIND_LOAD_COL
             && in_data.index <= 14'(csc_pkg::MaxVertices);
    col_waddr = in_data.index[VW:0];
    col_wdata = in_data.value;
    row_we = in_acc && in_data.kind == csc_pkg::KIND_LOAD_ROW
             && in_data.index < 14'(csc_pkg::MaxEdges);
    row_waddr = in_data.index[EW-1:0];
    row_wdata = in_data.value[VW-1:0];
    col_raddr = '0;
    row_raddr = m_ptr[EW-1:0];
    cnt_raddr = in_data.index[VW-1:0];
    cnt_we = 1'b0;
    cnt_waddr = bump.addr;
    cnt_wdata = (cnt_rdata == csc_pkg::Sat32) ? cnt_rdata : cnt_rdata + 32'd1;
    case (state)
      S_READ_WAIT: cnt_raddr = rd_vertex;
      S_READ_OUT: cnt_raddr = rd_vertex;
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_waddr = clr[VW-1:0];
        cnt_wdata = '0;
      end
      S_COL_A: col_raddr = {1'b0, vi[VW-1:0]};
      S_COL_B: col_raddr = vi + CW'(1);
      S_U_A: col_raddr = {1'b0, u};
      S_U_B: col_raddr = (VW + 1)'(u) + (VW + 1)'(1);
      S_K_CHECK: row_raddr = k_ptr[EW-1:0];
      S_SRCH_W: row_raddr = mid[EW-1:0];
      S_BUMP_R: cnt_raddr = bump.addr;
      S_BUMP_W: cnt_we = 1'b1;
      default: ;
    endcase
  end

  // Control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      clr_walk <= 1'b0;
      out_valid <= 1'b0;
      vertex_count <= 11'd1;
      edge_count <= '0;
      total <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == csc_pkg::REG_VERTEX_COUNT) vertex_count <= cfg_data[10:0];
        else edge_count <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && in_data.kind == csc_pkg::KIND_START) begin
            clr <= '0;
            clr_walk <= 1'b1;
            total <= '0;
            state <= S_CLEAR;
          end else if (in_acc && in_data.kind == csc_pkg::KIND_READ) begin
            rd_vertex <= in_data.index[9:0];
            rd_oor <= in_data.index >= 14'(csc_pkg::MaxVertices);
            state <= S_READ_WAIT;
          end
        end
        S_READ_WAIT: state <= S_READ_OUT;
        // Hold the result until the output register is empty
        S_READ_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.vertex <= rd_vertex;
            out_data.vertex_triangles <= rd_oor ? 32'd0 : cnt_rdata;
            out_data.total_triangles <= total;
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(csc_pkg::MaxVertices - 1)) begin
            vi <= '0;
            state <= clr_walk ? S_COL_A : S_IDLE;
          end
        end
        S_COL_A: state <= (vi >= nv) ? S_DONE : S_COL_B;
        S_COL_B: begin
          m_ptr <= colp;
          state <= S_COL_C;
        end
        S_COL_C: begin
          e_ptr <= colp;
          state <= S_M_CHECK;
        end
        S_M_CHECK: begin
          if (m_ptr >= e_ptr) begin
            vi <= vi + CW'(1);
            state <= S_COL_A;
          end else state <= S_M_ROW;
        end
        S_M_ROW: begin
          u <= row_rdata;
          state <= S_U_A;
        end
        S_U_A: begin
          k_ptr <= m_ptr + PW'(1);
          state <= S_U_B;
        end
        S_U_B: begin
          u_lo <= colp;
          state <= S_U_C;
        end
        S_U_C: begin
          u_hi <= colp;
          state <= S_K_CHECK;
        end
        S_K_CHECK: state <= (k_ptr >= e_ptr) ? S_NEXT_M : S_K_ROW;
        // Restart the search window for this key
        S_K_ROW: begin
          key <= row_rdata;
          lo <= u_lo;
          hi <= u_hi;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) state <= S_SRCH_W;
          else begin
            k_ptr <= k_ptr + PW'(1);
            state <= S_K_CHECK;
          end
        end
        S_SRCH_W: state <= S_SRCH_C;
        S_SRCH_C: begin
          if (row_rdata == key) begin
            bsel <= 2'd0;
            total <= (total == csc_pkg::Sat32) ? total : total + 32'd1;
            state <= S_BUMP_R;
          end else begin
            if (row_rdata < key) lo <= mid + PW'(1);
            else hi <= mid;
            state <= S_SRCH;
          end
        end
        S_BUMP_R: state <= S_BUMP_W;
        S_BUMP_W: begin
          if (bsel == 2'd2) begin
            k_ptr <= k_ptr + PW'(1);
            state <= S_K_CHECK;
          end else begin
            bsel <= bsel + 2'd1;
            state <= S_BUMP_R;
          end
        end
        S_NEXT_M: begin
          m_ptr <= m_ptr + PW'(1);
          state <= S_M_CHECK;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.vertex <= '0;
            out_data.vertex_triangles <= '0;
            out_data.total_triangles <= total;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Midpoint of the search window
  always_ff @(posedge clk) begin
    if (state == S_SRCH) mid <= lo + ((hi - lo) >> 1);
  end

  `CSC_ASSERT(a_no_in_busy, !(in_ready && state != S_IDLE), "input ready while busy")
  `CSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `CSC_ASSERT(a_clear_no_out, !(state == S_CLEAR && in_ready), "accepting during clear")
endmodule

// File: design/csc_ram.sv
`timescale 1ns / 1ps
module csc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: test/csc_triangle_counter_checker.sv
`timescale 1ns / 1ps
module csc_triangle_counter_checker
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  output int          errors,
  output int          pending
);

  logic [10:0] walk_limit;
  logic [13:0] edge_limit;
  logic [13:0] col_start [0:MaxVertices];
  logic [9:0]  row_of [0:MaxEdges-1];
  logic [31:0] tri_count [0:MaxVertices-1];
  logic [31:0] tri_total;
  out_t        answers [$];

  function automatic int clip(int p, int lim);
    return (p > lim) ? lim : p;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == Sat32) ? c : c + 32'd1;
  endfunction

  // Half-open binary search over one column
  function automatic bit row_found(int lo, int hi, logic [9:0] key);
    int mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (row_of[mid] == key) return 1'b1;
      if (row_of[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  // Clear counters and walk every column pair
  function automatic void count_triangles();
    int n, lim, i, m, k, b, e, lo, hi;
    logic [9:0] u, key;
    n = (walk_limit < MaxVertices) ? walk_limit : MaxVertices;
    lim = (edge_limit < MaxEdges) ? edge_limit : MaxEdges;
    for (i = 0; i < MaxVertices; i++) tri_count[i] = '0;
    tri_total = '0;
    for (i = 0; i < n; i++) begin
      b = clip(col_start[i], lim);
      e = clip(col_start[i+1], lim);
      for (m = b; m < e; m++) begin
        u = row_of[m];
        lo = clip(col_start[u], lim);
        hi = clip(col_start[int'(u) + 1], lim);
        for (k = m + 1; k < e; k++) begin
          key = row_of[k];
          if (row_found(lo, hi, key)) begin
            tri_count[i] = sat_inc(tri_count[i]);
            tri_count[u] = sat_inc(tri_count[u]);
            tri_count[key] = sat_inc(tri_count[key]);
            tri_total = sat_inc(tri_total);
          end
        end
      end
    end
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      walk_limit = 11'd1;
      edge_limit = '0;
      for (int i = 0; i < MaxVertices; i++) tri_count[i] = '0;
      tri_total = '0;
      answers.delete();
      errors = 0;
    end else begin
      // Compare results first: a result never belongs to this edge's request
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result vertex=%0d vtri=%0d total=%0d", $time,
                   out_data.vertex, out_data.vertex_triangles, out_data.total_triangles);
        end else begin
          want = answers.pop_front();
          if (out_data.vertex !== want.vertex) begin
            errors++;
            $display("%0t: vertex expected %0d got %0d", $time, want.vertex,
                     out_data.vertex);
          end
          if (out_data.vertex_triangles !== want.vertex_triangles) begin
            errors++;
            $display("%0t: vertex_triangles expected %0d got %0d", $time,
                     want.vertex_triangles, out_data.vertex_triangles);
          end
          if (out_data.total_triangles !== want.total_triangles) begin
            errors++;
            $display("%0t: total_triangles expected %0d got %0d", $time,
                     want.total_triangles, out_data.total_triangles);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERTEX_COUNT) walk_limit = cfg_data[10:0];
        else edge_limit = cfg_data;
      end
      // Apply the request to the graph copy
      if (in_valid && in_ready) begin
        case (in_data.kind)
          KIND_LOAD_COL: begin
            if (in_data.index <= MaxVertices) col_start[in_data.index] = in_data.value;
          end
          KIND_LOAD_ROW: begin
            if (in_data.index < MaxEdges) row_of[in_data.index] = in_data.value[9:0];
          end
          KIND_START: begin
            count_triangles();
            want.vertex = '0;
            want.vertex_triangles = '0;
            want.total_triangles = tri_total;
            answers.push_back(want);
          end
          default: begin
            want.vertex = in_data.index[9:0];
            want.vertex_triangles = (in_data.index < MaxVertices) ?
                                    tri_count[in_data.index] : '0;
            want.total_triangles = tri_total;
            answers.push_back(want);
          end
        endcase
      end
    end
  end

endmodule

// File: test/tb_csc_triangle_counter_core.sv
`timescale 1ns / 1ps
module tb_csc_triangle_counter_core;
  import csc_pkg::*;

  localparam int StallLimit = 200000;
  localparam int HoldCycles = 600;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [13:0] cfg_data;
  int          errors;
  int          pending;
  int          requests;
  int          idle_cycles;
  bit          send_burst;

  csc_triangle_counter_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  csc_triangle_counter_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_csc_triangle_counter_core: done, errors");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] kind, int index, int value);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.kind = kind;
    in_data.index = index[13:0];
    in_data.value = value[13:0];
    in_valid = 1'b1;
    #1;
    while (!in_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    requests++;
  endtask

  // Drain all results, then let trailing loads finish
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value[13:0];
    cfg_valid = 1'b1;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a random undirected graph in CSC form; rows sorted unless scrambled
  task automatic load_graph(int n, int dens, bit scramble, output int edges);
    bit adj [0:15][0:15];
    int lst [$];
    int a, b, t, j;
    for (a = 0; a < n; a++)
      for (b = a + 1; b < n; b++) begin
        adj[a][b] = ($urandom_range(0, 99) < dens);
        adj[b][a] = adj[a][b];
      end
    for (a = 0; a < n; a++) begin
      send(KIND_LOAD_COL, a, lst.size());
      for (b = 0; b < n; b++) if (adj[a][b]) lst.push_back(b);
    end
    send(KIND_LOAD_COL, n, lst.size());
    if (scramble && lst.size() > 1) begin
      a = $urandom_range(0, lst.size() - 1);
      b = $urandom_range(0, lst.size() - 1);
      t = lst[a];
      lst[a] = lst[b];
      lst[b] = t;
    end
    // Row values above the vertex range wrap back into it
    for (j = 0; j < lst.size(); j++)
      send(KIND_LOAD_ROW, j, lst[j] + 1024 * $urandom_range(0, 14));
    edges = lst.size();
  endtask

  task automatic read_some(int n, int cnt);
    for (int r = 0; r < cnt; r++)
      send(KIND_READ, ($urandom_range(0, 3) != 0) ? $urandom_range(0, n) :
           $urandom_range(0, 16383), 0);
  endtask

  // Receiver: random stalls, one long hold-off early on
  initial begin
    int results;
    int gap;
    bit no_stall;
    out_ready = 1'b0;
    results = 0;
    no_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (results % 40 == 39) no_stall = ($urandom_range(0, 3) == 0);
      gap = no_stall ? 0 : $urandom_range(0, 17);
      if (results == 12) gap = HoldCycles;
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      #1;
      while (!out_valid) begin
        @(negedge clk);
        #1;
      end
      @(posedge clk);
      results++;
    end
  end

  initial begin
    int edges, n, mode, p;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_VERTEX_COUNT;
    cfg_data = '0;
    requests = 0;
    send_burst = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, empty walk, out-of-range slots and reads
    send(KIND_LOAD_COL, 0, 0);
    send(KIND_LOAD_COL, 1, 0);
    send(KIND_READ, 0, 0);
    send(KIND_READ, 16383, 0);
    send(KIND_START, 0, 0);
    send(KIND_READ, 1023, 0);
    send(KIND_LOAD_COL, 1025, 5);
    send(KIND_LOAD_COL, 16383, 16383);
    send(KIND_LOAD_ROW, 8192, 3);
    send(KIND_LOAD_ROW, 16383, 16383);
    send(KIND_LOAD_ROW, 8191, 16383);
    settle();
    write_reg(REG_VERTEX_COUNT, 0);
    send(KIND_START, 0, 0);
    send(KIND_READ, 0, 0);
    load_graph(3, 100, 1'b0, edges);
    settle();
    write_reg(REG_VERTEX_COUNT, 3);
    write_reg(REG_EDGE_COUNT, edges);
    send(KIND_START, 0, 0);
    for (int v = 0; v < 4; v++) send(KIND_READ, v, 0);

    // Full span: every column pointer written, oversized walk and edge limit
    load_graph(12, 60, 1'b0, edges);
    for (int c = 13; c <= MaxVertices; c++) send(KIND_LOAD_COL, c, edges);
    settle();
    write_reg(REG_VERTEX_COUNT, 2047);
    write_reg(REG_EDGE_COUNT, 16383);
    send(KIND_START, 0, 0);
    send_burst = 1'b1;
    read_some(12, 30);
    send_burst = 1'b0;

    // Random graphs under varied limits
    while (requests < 1700) begin
      send_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 16);
      load_graph(n, $urandom_range(10, 100), $urandom_range(0, 4) == 0, edges);
      mode = $urandom_range(0, 5);
      // Stray pointers only where the edge limit stays inside loaded rows
      if (mode == 1) begin
        p = $urandom_range(0, n);
        send(KIND_LOAD_COL, p, $urandom_range(0, 16383));
      end
      if ($urandom_range(0, 5) == 0) send(KIND_LOAD_ROW, $urandom_range(8192, 16383),
                                          $urandom_range(0, 16383));
      settle();
      write_reg(REG_VERTEX_COUNT, (mode == 4) ? 0 : (mode == 5) ? n - 1 : n);
      write_reg(REG_EDGE_COUNT, (mode == 1) ? $urandom_range(0, edges) :
                (mode == 2) ? 16383 : edges);
      send(KIND_START, 0, 0);
      read_some(n, $urandom_range(2, 8));
    end

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_csc_triangle_counter_core: done, clean");
    end else begin
      $display("tb_csc_triangle_counter_core: done, errors");
    end
    $finish;
  end

endmodule
